FILE: sv/kcm_pkg.sv
// Shared types and constants of the keystroke calculator with memory.
package kcm_pkg;

    localparam int OUT_WIDTH = 32;
    localparam int KEY_WIDTH = 5;

    typedef logic [KEY_WIDTH-1:0]        t_key;
    typedef logic signed [OUT_WIDTH-1:0] t_sword;

    localparam t_key KEY_DIGIT_MAX = 5'd9;
    localparam t_key KEY_ADD       = 5'd10;
    localparam t_key KEY_SUB       = 5'd11;
    localparam t_key KEY_MUL       = 5'd12;
    localparam t_key KEY_DIV       = 5'd13;
    localparam t_key KEY_EQU       = 5'd14;
    localparam t_key KEY_SIGN      = 5'd15;
    localparam t_key KEY_MCLR      = 5'd16;
    localparam t_key KEY_MRCL      = 5'd17;
    localparam t_key KEY_MPLUS     = 5'd18;
    localparam t_key KEY_MMINUS    = 5'd19;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQU = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_NEGA,
        U_NEGB,
        U_STEP,
        U_FIX,
        U_DONE
    } t_ustate;

    typedef struct packed {
        logic start;
        logic div;
    } t_md_req;

    typedef struct packed {
        logic done;
        logic dz;
    } t_md_rsp;

endpackage

FILE: sv/kcm_if.sv
// Valid/ready channel interfaces for key items and result items.
interface kcm_key_if;
    logic          valid;
    logic          ready;
    kcm_pkg::t_key key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface kcm_res_if;
    logic            valid;
    logic            ready;
    kcm_pkg::t_sword accumulator_value;
    kcm_pkg::t_sword entry_value;
    kcm_pkg::t_sword memory_value;
    logic            divide_by_zero;

    modport source (output valid, output accumulator_value, output entry_value,
                    output memory_value, output divide_by_zero, input ready);
    modport sink   (input valid, input accumulator_value, input entry_value,
                    input memory_value, input divide_by_zero, output ready);
endinterface

FILE: sv/keystroke_calculator_with_memory.sv
// Keystroke calculator with memory: key sequencer, state registers and result register.
// One key item at a time; ready is high only while the sequencer is idle.
// Keys with no multiply or divide: result registered through the exec and done states.
// Multiply and divide wait in the calc state for the shared one-bit-per-cycle unit; the
// next accept comes as the result register loads, later while an earlier result waits.
// Synchronous active-low reset: acc, entry, mem 0.
module keystroke_calculator_with_memory #(
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kcm_key_if.sink    i_key,
    kcm_res_if.source  o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int OW = kcm_pkg::OUT_WIDTH;

    kcm_pkg::t_state  r_state, n_state;
    kcm_pkg::t_key    r_key, n_key;
    logic             r_entering, n_entering;
    logic [DW-1:0]    r_entry, n_entry;
    logic [DW-1:0]    r_acc, n_acc;
    logic [DW-1:0]    r_mem, n_mem;
    kcm_pkg::t_op     r_pend, n_pend;
    logic [DW-1:0]    r_opres, n_opres;
    logic             r_dz, n_dz;
    logic             r_out_valid, n_out_valid;
    logic [OW-1:0]    r_out_acc, n_out_acc;
    logic [OW-1:0]    r_out_entry, n_out_entry;
    logic [OW-1:0]    r_out_mem, n_out_mem;
    logic             r_out_dz, n_out_dz;

    logic             s_is_digit;
    logic             s_is_opkey;
    logic             s_is_mem;
    logic             s_apply;
    logic             s_use_unit;
    logic             s_out_free;
    logic [DW-1:0]    s_times10;
    logic [DW-1:0]    s_digit;
    kcm_pkg::t_md_req s_req;
    kcm_pkg::t_md_rsp s_rsp;
    logic [DW-1:0]    s_unit_res;

    assign s_is_digit = (r_key <= kcm_pkg::KEY_DIGIT_MAX);
    assign s_is_opkey = (r_key >= kcm_pkg::KEY_ADD) && (r_key <= kcm_pkg::KEY_EQU);
    assign s_is_mem   = (r_key == kcm_pkg::KEY_MPLUS) || (r_key == kcm_pkg::KEY_MMINUS);
    assign s_apply    = (s_is_opkey && r_entering) || s_is_mem;
    assign s_use_unit = s_apply && ((r_pend == kcm_pkg::OP_MUL) || (r_pend == kcm_pkg::OP_DIV));
    assign s_out_free = !r_out_valid || o_res.ready;
    assign s_times10  = {r_entry[DW-4:0], 3'b000} + {r_entry[DW-2:0], 1'b0};
    assign s_digit    = DW'(r_key);

    assign s_req.start = (r_state == kcm_pkg::ST_EXEC) && s_use_unit;
    assign s_req.div   = (r_pend == kcm_pkg::OP_DIV);

    kcm_muldiv #(
        .W (DW)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (s_req),
        .i_a      (r_acc),
        .i_b      (r_entry),
        .o_rsp    (s_rsp),
        .o_result (s_unit_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kcm_pkg::ST_IDLE: begin
                if (i_key.valid) begin
                    n_state = kcm_pkg::ST_EXEC;
                end
            end
            kcm_pkg::ST_EXEC: begin
                n_state = s_use_unit ? kcm_pkg::ST_CALC : kcm_pkg::ST_DONE;
            end
            kcm_pkg::ST_CALC: begin
                if (s_rsp.done) begin
                    n_state = kcm_pkg::ST_DONE;
                end
            end
            kcm_pkg::ST_DONE: begin
                if (s_out_free) begin
                    n_state = kcm_pkg::ST_IDLE;
                end
            end
            default: n_state = kcm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_key       = r_key;
        n_entering  = r_entering;
        n_entry     = r_entry;
        n_acc       = r_acc;
        n_mem       = r_mem;
        n_pend      = r_pend;
        n_opres     = r_opres;
        n_dz        = r_dz;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_acc   = r_out_acc;
        n_out_entry = r_out_entry;
        n_out_mem   = r_out_mem;
        n_out_dz    = r_out_dz;
        unique case (r_state)
            kcm_pkg::ST_IDLE: begin
                if (i_key.valid) begin
                    n_key = i_key.key;
                end
            end
            kcm_pkg::ST_EXEC: begin
                n_dz = 1'b0;
                if (s_is_digit) begin
                    n_opres = r_entry[DW-1] ? (s_times10 - s_digit) : (s_times10 + s_digit);
                end else begin
                    unique case (r_pend)
                        kcm_pkg::OP_ADD: n_opres = r_acc + r_entry;
                        kcm_pkg::OP_SUB: n_opres = r_acc - r_entry;
                        kcm_pkg::OP_EQU: n_opres = r_acc;
                        default:         n_opres = '0;
                    endcase
                end
            end
            kcm_pkg::ST_CALC: begin
                if (s_rsp.done) begin
                    n_opres = s_unit_res;
                    n_dz    = s_rsp.dz;
                end
            end
            kcm_pkg::ST_DONE: begin
                if (s_out_free) begin
                    priority if (s_is_digit) begin
                        n_entry    = r_entering ? r_opres : s_digit;
                        n_entering = 1'b1;
                    end else if (s_is_opkey) begin
                        if (r_entering) begin
                            n_acc      = r_opres;
                            n_entering = 1'b0;
                        end
                        n_pend = kcm_pkg::t_op'(3'(r_key - kcm_pkg::KEY_ADD));
                    end else if (r_key == kcm_pkg::KEY_SIGN) begin
                        n_entry = '0 - r_entry;
                    end else if (r_key == kcm_pkg::KEY_MCLR) begin
                        n_mem = '0;
                    end else if (r_key == kcm_pkg::KEY_MRCL) begin
                        n_acc = r_mem;
                    end else if (s_is_mem) begin
                        n_mem      = (r_key == kcm_pkg::KEY_MPLUS) ? (r_mem + r_opres)
                                                                   : (r_mem - r_opres);
                        n_acc      = '0;
                        n_entry    = '0;
                        n_pend     = kcm_pkg::OP_ADD;
                        n_entering = 1'b0;
                    end else begin
                    end
                    n_out_valid = 1'b1;
                    n_out_acc   = OW'(n_acc);
                    n_out_entry = OW'(n_entry);
                    n_out_mem   = OW'(n_mem);
                    n_out_dz    = r_dz;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcm_pkg::ST_IDLE;
            r_entering  <= 1'b0;
            r_entry     <= '0;
            r_acc       <= '0;
            r_mem       <= '0;
            r_pend      <= kcm_pkg::OP_ADD;
            r_dz        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entering  <= n_entering;
            r_entry     <= n_entry;
            r_acc       <= n_acc;
            r_mem       <= n_mem;
            r_pend      <= n_pend;
            r_dz        <= n_dz;
            r_out_valid <= n_out_valid;
        end
        r_key       <= n_key;
        r_opres     <= n_opres;
        r_out_acc   <= n_out_acc;
        r_out_entry <= n_out_entry;
        r_out_mem   <= n_out_mem;
        r_out_dz    <= n_out_dz;
    end

    assign i_key.ready             = (r_state == kcm_pkg::ST_IDLE);
    assign o_res.valid             = r_out_valid;
    assign o_res.accumulator_value = r_out_acc;
    assign o_res.entry_value       = r_out_entry;
    assign o_res.memory_value      = r_out_mem;
    assign o_res.divide_by_zero    = r_out_dz;

    a_unit_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rsp.done |-> (r_state == kcm_pkg::ST_CALC))
        else $error("multiply/divide unit finished outside of a calculation");

    a_dz_only_on_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kcm_pkg::ST_DONE) && r_dz) |-> (r_pend == kcm_pkg::OP_DIV))
        else $error("divide-by-zero flag without a pending divide");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key.valid && i_key.ready) |=> (r_state == kcm_pkg::ST_EXEC))
        else $error("accepted item did not start execution");

endmodule

FILE: sv/kcm_muldiv.sv
// Iterative shift-add multiplier and restoring signed divider on one shared adder.
module kcm_muldiv #(
    parameter int W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kcm_pkg::t_md_req i_req,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output kcm_pkg::t_md_rsp o_rsp,
    output logic [W-1:0]     o_result
);

    localparam int CW = $clog2(W);

    kcm_pkg::t_ustate r_ust, n_ust;
    logic             r_div, n_div;
    logic [W-1:0]     r_a, n_a;
    logic [W-1:0]     r_b, n_b;
    logic [W-1:0]     r_p, n_p;
    logic [W-1:0]     r_res, n_res;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic             r_dz, n_dz;

    logic [W:0]       s_x, s_y;
    logic             s_sub;
    logic [W+1:0]     s_sum;
    logic             s_ge;
    logic             s_last;

    assign s_sum  = {1'b0, s_x} + {1'b0, (s_sub ? ~s_y : s_y)} + (W+2)'(s_sub);
    assign s_ge   = s_sum[W+1];
    assign s_last = (r_cnt == CW'(W-1));

    always_comb begin
        s_x   = '0;
        s_y   = '0;
        s_sub = 1'b0;
        unique case (r_ust)
            kcm_pkg::U_NEGA: begin
                s_y   = {1'b0, r_a};
                s_sub = 1'b1;
            end
            kcm_pkg::U_NEGB: begin
                s_y   = {1'b0, r_b};
                s_sub = 1'b1;
            end
            kcm_pkg::U_STEP: begin
                if (r_div) begin
                    s_x   = {r_p, r_a[W-1]};
                    s_y   = {1'b0, r_b};
                    s_sub = 1'b1;
                end else begin
                    s_x   = {1'b0, r_p};
                    s_y   = {1'b0, r_b};
                end
            end
            kcm_pkg::U_FIX: begin
                s_y   = {1'b0, r_a};
                s_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ust = r_ust;
        unique case (r_ust)
            kcm_pkg::U_IDLE: begin
                if (i_req.start) begin
                    if (i_req.div && (i_b == '0)) begin
                        n_ust = kcm_pkg::U_DONE;
                    end else if (i_req.div) begin
                        n_ust = kcm_pkg::U_NEGA;
                    end else begin
                        n_ust = kcm_pkg::U_STEP;
                    end
                end
            end
            kcm_pkg::U_NEGA: n_ust = kcm_pkg::U_NEGB;
            kcm_pkg::U_NEGB: n_ust = kcm_pkg::U_STEP;
            kcm_pkg::U_STEP: begin
                if (s_last) begin
                    n_ust = kcm_pkg::U_FIX;
                end
            end
            kcm_pkg::U_FIX:  n_ust = kcm_pkg::U_DONE;
            kcm_pkg::U_DONE: n_ust = kcm_pkg::U_IDLE;
            default:         n_ust = kcm_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        n_div = r_div;
        n_a   = r_a;
        n_b   = r_b;
        n_p   = r_p;
        n_res = r_res;
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_dz  = r_dz;
        unique case (r_ust)
            kcm_pkg::U_IDLE: begin
                if (i_req.start) begin
                    n_div = i_req.div;
                    n_a   = i_a;
                    n_b   = i_b;
                    n_p   = '0;
                    n_cnt = '0;
                    n_neg = i_a[W-1] ^ i_b[W-1];
                    n_dz  = i_req.div && (i_b == '0);
                    n_res = i_a;
                end
            end
            kcm_pkg::U_NEGA: begin
                if (r_a[W-1]) begin
                    n_a = s_sum[W-1:0];
                end
            end
            kcm_pkg::U_NEGB: begin
                if (r_b[W-1]) begin
                    n_b = s_sum[W-1:0];
                end
            end
            kcm_pkg::U_STEP: begin
                n_cnt = r_cnt + CW'(1);
                if (r_div) begin
                    n_p = s_ge ? s_sum[W-1:0] : s_x[W-1:0];
                    n_a = {r_a[W-2:0], s_ge};
                end else begin
                    if (r_a[0]) begin
                        n_p = s_sum[W-1:0];
                    end
                    n_b = {r_b[W-2:0], 1'b0};
                    n_a = {1'b0, r_a[W-1:1]};
                end
            end
            kcm_pkg::U_FIX: begin
                if (r_div) begin
                    n_res = r_neg ? s_sum[W-1:0] : r_a;
                end else begin
                    n_res = r_p;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ust <= kcm_pkg::U_IDLE;
            r_dz  <= 1'b0;
        end else begin
            r_ust <= n_ust;
            r_dz  <= n_dz;
        end
        r_div <= n_div;
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
        r_res <= n_res;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_rsp.done = (r_ust == kcm_pkg::U_DONE);
    assign o_rsp.dz   = r_dz;
    assign o_result   = r_res;

endmodule

FILE: bench/tb_keystroke_calculator_with_memory.sv
// Self-checking testbench for the keystroke calculator with memory.
module tb_keystroke_calculator_with_memory;

    localparam int              OW             = kcm_pkg::OUT_WIDTH;
    localparam kcm_pkg::t_key   KEY_UNUSED_MIN = 5'd20;
    localparam kcm_pkg::t_sword MOST_NEG       = {1'b1, {(OW-1){1'b0}}};
    localparam int              RANDOM_KEYS    = 1650;

    typedef struct packed {
        kcm_pkg::t_sword acc;
        kcm_pkg::t_sword ent;
        kcm_pkg::t_sword mem;
        logic            dz;
    } t_calc_out;

    typedef struct packed {
        kcm_pkg::t_key k;
        logic          typed;
        t_calc_out     res;
    } t_key_row;

    logic clk;
    logic rst_n;

    kcm_key_if key_ch ();
    kcm_res_if res_ch ();

    keystroke_calculator_with_memory i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_key   (key_ch),
        .o_res   (res_ch)
    );

    // calculator state as the block should hold it
    logic            calc_entering = 1'b0;
    kcm_pkg::t_sword calc_entry    = '0;
    kcm_pkg::t_sword calc_acc      = '0;
    kcm_pkg::t_op    calc_op       = kcm_pkg::OP_ADD;
    kcm_pkg::t_sword calc_mem      = '0;

    t_calc_out calc_expect_q[$];
    t_calc_out calc_oldest;
    t_key_row  dir_rows[$];

    int send_idle_pct  = 21;
    int recv_stall_pct = 88;
    int mismatches     = 0;
    int keys_sent      = 0;
    int keys_counted   = 0;
    int results_seen   = 0;
    int dz_seen        = 0;

    // {divide_by_zero, value}
    function automatic logic [OW:0] apply_op(kcm_pkg::t_sword a, kcm_pkg::t_op op,
                                             kcm_pkg::t_sword b);
        kcm_pkg::t_sword q;
        case (op)
            kcm_pkg::OP_ADD: return {1'b0, a + b};
            kcm_pkg::OP_SUB: return {1'b0, a - b};
            kcm_pkg::OP_MUL: return {1'b0, a * b};
            kcm_pkg::OP_DIV: begin
                if (b == 0)
                    return {1'b1, a};
                if (b == -1)
                    return {1'b0, -a};
                q = a / b;
                return {1'b0, q};
            end
            kcm_pkg::OP_EQU: return {1'b0, a};
            default: return '0;
        endcase
    endfunction

    function automatic t_calc_out calc_key_result(kcm_pkg::t_key k);
        t_calc_out       r;
        logic [OW:0]     op_res;
        logic [4:0]      op_code;
        kcm_pkg::t_sword digit;
        r.dz  = 1'b0;
        digit = {{(OW-kcm_pkg::KEY_WIDTH){1'b0}}, k};
        if (k <= kcm_pkg::KEY_DIGIT_MAX) begin
            if (!calc_entering) begin
                calc_entry    = digit;
                calc_entering = 1'b1;
            end else if (calc_entry[OW-1]) begin
                calc_entry = calc_entry * 10 - digit;
            end else begin
                calc_entry = calc_entry * 10 + digit;
            end
        end else if (k <= kcm_pkg::KEY_EQU) begin
            if (calc_entering) begin
                op_res        = apply_op(calc_acc, calc_op, calc_entry);
                calc_acc      = op_res[OW-1:0];
                r.dz          = op_res[OW];
                calc_entering = 1'b0;
            end
            op_code = k - kcm_pkg::KEY_ADD;
            calc_op = kcm_pkg::t_op'(op_code[2:0]);
        end else if (k == kcm_pkg::KEY_SIGN) begin
            calc_entry = -calc_entry;
        end else if (k == kcm_pkg::KEY_MCLR) begin
            calc_mem = '0;
        end else if (k == kcm_pkg::KEY_MRCL) begin
            calc_acc = calc_mem;
        end else if (k == kcm_pkg::KEY_MPLUS || k == kcm_pkg::KEY_MMINUS) begin
            op_res   = apply_op(calc_acc, calc_op, calc_entry);
            calc_acc = op_res[OW-1:0];
            r.dz     = op_res[OW];
            if (k == kcm_pkg::KEY_MPLUS)
                calc_mem = calc_mem + calc_acc;
            else
                calc_mem = calc_mem - calc_acc;
            calc_acc      = '0;
            calc_entry    = '0;
            calc_op       = kcm_pkg::OP_ADD;
            calc_entering = 1'b0;
        end
        r.acc = calc_acc;
        r.ent = calc_entry;
        r.mem = calc_mem;
        return r;
    endfunction

    function automatic t_key_row plain(kcm_pkg::t_key k);
        t_key_row row;
        row       = '0;
        row.k     = k;
        return row;
    endfunction

    function automatic t_key_row known(kcm_pkg::t_key k, kcm_pkg::t_sword acc,
                                       kcm_pkg::t_sword ent, kcm_pkg::t_sword mem,
                                       logic dz);
        t_key_row row;
        row.k       = k;
        row.typed   = 1'b1;
        row.res.acc = acc;
        row.res.ent = ent;
        row.res.mem = mem;
        row.res.dz  = dz;
        return row;
    endfunction

    task automatic send_key(t_key_row row);
        t_calc_out predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key   <= row.k;
        do @(posedge clk); while (!key_ch.ready);
        predicted = calc_key_result(row.k);
        calc_expect_q.push_back(row.typed ? row.res : predicted);
        keys_sent++;
        if (row.k < KEY_UNUSED_MIN)
            keys_counted++;
    endtask

    // a number of random digits, maybe negated, closed by an operator or memory key
    task automatic send_number_and_key();
        int            ndig;
        kcm_pkg::t_key term;
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        repeat (ndig)
            send_key(plain(kcm_pkg::t_key'($urandom_range(0, 9))));
        if ($urandom_range(0, 5) == 0)
            send_key(plain(kcm_pkg::KEY_SIGN));
        if ($urandom_range(0, 3) == 0)
            term = kcm_pkg::t_key'(kcm_pkg::KEY_MCLR + $urandom_range(0, 3));
        else
            term = kcm_pkg::t_key'(kcm_pkg::KEY_ADD + $urandom_range(0, 4));
        send_key(plain(term));
    endtask

    task automatic check_field(string name, kcm_pkg::t_sword want, kcm_pkg::t_sword got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (calc_expect_q.size() == 0) begin
                mismatches++;
                $display({"%0t: unexpected result item: expected none, ",
                          "got acc %0d entry %0d mem %0d dz %0b"},
                         $time, res_ch.accumulator_value, res_ch.entry_value,
                         res_ch.memory_value, res_ch.divide_by_zero);
            end else begin
                calc_oldest = calc_expect_q.pop_front();
                check_field("accumulator_value", calc_oldest.acc, res_ch.accumulator_value);
                check_field("entry_value", calc_oldest.ent, res_ch.entry_value);
                check_field("memory_value", calc_oldest.mem, res_ch.memory_value);
                check_field("divide_by_zero", kcm_pkg::t_sword'(calc_oldest.dz),
                            kcm_pkg::t_sword'(res_ch.divide_by_zero));
                results_seen++;
                if (res_ch.divide_by_zero)
                    dz_seen++;
            end
        end
    end

    initial begin
        #(10 * 1_000_000);
        $display("keystroke_calculator_with_memory test failed");
        $finish;
    end

    initial begin
        rst_n        <= 1'b0;
        key_ch.valid <= 1'b0;
        key_ch.key   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back(known(5'd0,               0,        0,        0, 1'b0));
        dir_rows.push_back(known(5'd9,               0,        9,        0, 1'b0));
        dir_rows.push_back(known(kcm_pkg::KEY_DIV,   9,        9,        0, 1'b0));
        dir_rows.push_back(known(5'd0,               9,        0,        0, 1'b0));
        dir_rows.push_back(known(kcm_pkg::KEY_EQU,   9,        0,        0, 1'b1));
        dir_rows.push_back(known(kcm_pkg::KEY_MPLUS, 0,        0,        9, 1'b0));
        // 2147483648 typed in wraps to the most negative entry
        dir_rows.push_back(plain(5'd2));
        dir_rows.push_back(plain(5'd1));
        dir_rows.push_back(plain(5'd4));
        dir_rows.push_back(plain(5'd7));
        dir_rows.push_back(plain(5'd4));
        dir_rows.push_back(plain(5'd8));
        dir_rows.push_back(plain(5'd3));
        dir_rows.push_back(plain(5'd6));
        dir_rows.push_back(plain(5'd4));
        dir_rows.push_back(known(5'd8,               0,        MOST_NEG, 9, 1'b0));
        dir_rows.push_back(known(kcm_pkg::KEY_DIV,   MOST_NEG, MOST_NEG, 9, 1'b0));
        dir_rows.push_back(plain(5'd1));
        dir_rows.push_back(plain(kcm_pkg::KEY_SIGN));
        dir_rows.push_back(known(kcm_pkg::KEY_EQU,   MOST_NEG, -1,       9, 1'b0));
        dir_rows.push_back(plain(kcm_pkg::KEY_MUL));
        dir_rows.push_back(plain(5'd9));
        dir_rows.push_back(plain(kcm_pkg::KEY_MMINUS));
        dir_rows.push_back(plain(5'd31));
        dir_rows.push_back(plain(kcm_pkg::KEY_SUB));
        dir_rows.push_back(plain(kcm_pkg::KEY_MRCL));
        dir_rows.push_back(plain(kcm_pkg::KEY_MCLR));

        foreach (dir_rows[i])
            send_key(dir_rows[i]);

        keys_counted = 0;
        while (keys_counted < RANDOM_KEYS) begin
            if (keys_counted >= 2 * RANDOM_KEYS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (keys_counted >= RANDOM_KEYS / 3) begin
                send_idle_pct  = 88;
                recv_stall_pct = 21;
            end
            if ($urandom_range(0, 9) == 0)
                send_key(plain(kcm_pkg::t_key'($urandom_range(0, 31))));
            else
                send_number_and_key();
        end
        key_ch.valid   <= 1'b0;
        recv_stall_pct = 0;

        while (calc_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Sent %0d keys (directed edge cases, then random key sequences).", keys_sent);
        $display("Checked %0d result items, %0d of them with divide by zero.",
                 results_seen, dz_seen);
        if (mismatches == 0)
            $display("keystroke_calculator_with_memory test passed");
        else
            $display("keystroke_calculator_with_memory test failed");
        $finish;
    end

endmodule
